/* rtl/ovca_pkg.sv */
// Shared types and constants of the output VC credit allocator.
package ovca_pkg;

	localparam int FUNC_W = 2;
	localparam int VC_W = 4;
	localparam int VNET_W = 2;
	localparam int CRED_W = 5;
	localparam int CNT_W = 3;

	localparam logic [CRED_W-1:0] CREDITS_RESET = 5'd4;
	localparam logic [CNT_W-1:0] CNT_MAX = 3'd7;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_CREDIT = 2'd0,
		FUNC_ALLOC = 2'd1,
		FUNC_SEND = 2'd2,
		FUNC_QUERY = 2'd3
	} func_t;

	typedef struct packed {
		func_t func;
		logic [VC_W-1:0] vc;
		logic [VNET_W-1:0] vnet;
		logic free_signal;
	} req_t;

endpackage

/* rtl/output_vc_credit_allocator.sv */
// An accepted request enters stage one with its memory reads; its result is then registered.
// No request is accepted while another is in stage one doing its read-modify-write of state.
// Each result is shown for one cycle with done high; busy is high in the cycle after acceptance.
// Reset: all VCs idle, every credit count at 4, credits_q at 4, no request in flight.
// The receiver cannot stall; results are never held off.
module output_vc_credit_allocator #(
	parameter int NUM_VNETS = 4,
	parameter int VCS_PER_VNET = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [ovca_pkg::FUNC_W-1:0] func,
	input  logic [ovca_pkg::VC_W-1:0] vc,
	input  logic [ovca_pkg::VNET_W-1:0] vnet,
	input  logic free_signal,
	input  logic cfg_we,
	input  logic [ovca_pkg::CRED_W-1:0] cfg_wdata,
	output logic done,
	output logic grant_valid,
	output logic [ovca_pkg::VC_W-1:0] granted_vc,
	output logic free_vc_available,
	output logic credit_available,
	output logic [ovca_pkg::CNT_W-1:0] active_count,
	output logic underflow_error
);

	import ovca_pkg::*;

	localparam int TOTAL_VCS = NUM_VNETS * VCS_PER_VNET;
	localparam int VC_SPAN = 1 << VC_W;
	localparam int CRED_DEPTH = (TOTAL_VCS < VC_SPAN) ? TOTAL_VCS : VC_SPAN;
	localparam int CA_W = (CRED_DEPTH > 1) ? $clog2(CRED_DEPTH) : 1;
	localparam int ROW_W = (NUM_VNETS > 1) ? $clog2(NUM_VNETS) : 1;
	localparam int COL_W = (VCS_PER_VNET > 1) ? $clog2(VCS_PER_VNET) : 1;
	localparam int POP_W = $clog2(VCS_PER_VNET + 1) + 1;
	localparam logic [7:0] VPV8 = 8'(VCS_PER_VNET);

	// Row and column of every reachable VC index, worked out at elaboration.
	logic [ROW_W-1:0] row_tab [VC_SPAN];
	logic [COL_W-1:0] col_tab [VC_SPAN];

	for (genvar v = 0; v < VC_SPAN; v++) begin : g_tab
		localparam int ROW_C = (v < TOTAL_VCS) ? (v / VCS_PER_VNET) : 0;
		localparam int COL_C = (v < TOTAL_VCS) ? (v % VCS_PER_VNET) : 0;
		assign row_tab[v] = ROW_W'(ROW_C);
		assign col_tab[v] = COL_W'(COL_C);
	end

	logic accept;
	logic [CRED_W-1:0] credits_q;

	logic valid_s1;
	req_t req_s1;
	logic vc_ok_s1;
	logic vnet_ok_s1;
	logic [ROW_W-1:0] vc_row_s1;
	logic [COL_W-1:0] vc_col_s1;
	logic [ROW_W-1:0] vnet_row_s1;

	logic [ROW_W+VNET_W-1:0] vnet_wide;
	logic [CA_W+VC_W-1:0] vc_wide;
	logic [ROW_W-1:0] vnet_row_in;
	logic [CA_W-1:0] cred_idx_in;
	logic [CA_W-1:0] cred_idx_s1;
	logic vc_ok_in;
	logic vnet_ok_in;

	logic [VCS_PER_VNET-1:0] vnet_row_rd;
	logic [VCS_PER_VNET-1:0] vc_row_rd;
	logic [CRED_W-1:0] cred_rd;

	logic act_we;
	logic [ROW_W-1:0] act_waddr;
	logic [VCS_PER_VNET-1:0] act_wdata;
	logic cred_we;

	logic [VCS_PER_VNET-1:0] vc_row_new;
	logic [VCS_PER_VNET-1:0] vnet_row_new;
	logic [CRED_W-1:0] cred_new;
	logic gv;
	logic [COL_W-1:0] gcol;
	logic uf;
	logic [POP_W-1:0] pop;
	logic [CNT_W-1:0] cnt;
	logic avail;
	logic [7:0] base;
	logic [VC_W-1:0] gvc;

	assign accept = start && !busy;
	assign busy = valid_s1;

	assign vnet_wide = {{ROW_W{1'b0}}, vnet};
	assign vnet_row_in = vnet_wide[ROW_W-1:0];
	assign vc_wide = {{CA_W{1'b0}}, vc};
	assign cred_idx_in = vc_wide[CA_W-1:0];
	assign vc_ok_in = {5'b0, vc} < 9'(TOTAL_VCS);
	assign vnet_ok_in = {3'b0, vnet} < 5'(NUM_VNETS);

	ovca_active_mem #(
		.DEPTH(NUM_VNETS),
		.WIDTH(VCS_PER_VNET),
		.AW(ROW_W)
	) u_active (
		.clk(clk),
		.arst_n(arst_n),
		.raddr_a(vnet_row_in),
		.raddr_b(row_tab[vc]),
		.rdata_a(vnet_row_rd),
		.rdata_b(vc_row_rd),
		.we(act_we),
		.waddr(act_waddr),
		.wdata(act_wdata)
	);

	ovca_credit_mem #(
		.DEPTH(CRED_DEPTH),
		.AW(CA_W)
	) u_credit (
		.clk(clk),
		.arst_n(arst_n),
		.raddr(cred_idx_in),
		.rdata(cred_rd),
		.we(cred_we),
		.waddr(cred_idx_s1),
		.wdata(cred_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credits_q <= CREDITS_RESET;
			valid_s1 <= 1'b0;
			done <= 1'b0;
		end else begin
			if (cfg_we) begin
				credits_q <= cfg_wdata;
			end
			valid_s1 <= accept;
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= '{func: func_t'(func), vc: vc, vnet: vnet, free_signal: free_signal};
			vc_ok_s1 <= vc_ok_in;
			vnet_ok_s1 <= vnet_ok_in;
			vc_row_s1 <= row_tab[vc];
			vc_col_s1 <= col_tab[vc];
			vnet_row_s1 <= vnet_row_in;
			cred_idx_s1 <= cred_idx_in;
		end
	end

	// Modify the rows and count read for the request in stage one and write them back.
	always_comb begin
		cred_new = cred_rd;
		cred_we = 1'b0;
		uf = 1'b0;
		gv = 1'b0;
		gcol = '0;
		vc_row_new = vc_row_rd;
		vnet_row_new = vnet_row_rd;
		act_we = 1'b0;
		act_waddr = vnet_row_s1;
		act_wdata = vnet_row_rd;
		case (req_s1.func)
			FUNC_CREDIT: begin
				if (vc_ok_s1) begin
					cred_we = 1'b1;
					if (cred_rd < credits_q) begin
						cred_new = cred_rd + 5'd1;
					end
					if (req_s1.free_signal) begin
						vc_row_new[vc_col_s1] = 1'b0;
						act_we = 1'b1;
						act_waddr = vc_row_s1;
						act_wdata = vc_row_new;
						// The freed VC may belong to the vnet group being reported.
						if (vnet_ok_s1 && (vc_row_s1 == vnet_row_s1)) begin
							vnet_row_new = vc_row_new;
						end
					end
				end
			end
			FUNC_ALLOC: begin
				if (vnet_ok_s1) begin
					for (int k = 0; k < VCS_PER_VNET; k++) begin
						if (!gv && !vnet_row_rd[k]) begin
							gv = 1'b1;
							gcol = COL_W'(k);
						end
					end
					if (gv) begin
						vnet_row_new[gcol] = 1'b1;
						act_we = 1'b1;
						act_waddr = vnet_row_s1;
						act_wdata = vnet_row_new;
					end
				end
			end
			FUNC_SEND: begin
				if (vc_ok_s1) begin
					if (cred_rd == '0) begin
						uf = 1'b1;
					end else begin
						cred_new = cred_rd - 5'd1;
						cred_we = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		if (!valid_s1) begin
			act_we = 1'b0;
			cred_we = 1'b0;
		end
	end

	always_comb begin
		pop = '0;
		for (int k = 0; k < VCS_PER_VNET; k++) begin
			pop = pop + POP_W'(vnet_row_new[k]);
		end
	end

	assign cnt = (pop > POP_W'(CNT_MAX)) ? CNT_MAX : CNT_W'(pop);
	assign avail = vnet_ok_s1 && !(&vnet_row_new);
	assign base = {6'b0, req_s1.vnet} * VPV8;
	assign gvc = base[VC_W-1:0] + VC_W'({3'b0, gcol});

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			grant_valid <= gv;
			granted_vc <= gv ? gvc : '0;
			free_vc_available <= avail;
			credit_available <= vc_ok_s1 && (cred_new != '0);
			active_count <= vnet_ok_s1 ? cnt : '0;
			underflow_error <= uf;
		end
	end

endmodule

/* rtl/ovca_active_mem.sv */
// Active-mark memory: one row of VC marks per vnet, two read ports, one write port.
module ovca_active_mem #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 4,
	parameter int AW = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;
	logic rv_a_q;
	logic rv_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_a_q <= mem[raddr_a];
		rd_b_q <= mem[raddr_b];
	end

	// A row that was never written reads as all idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rv_a_q <= 1'b0;
			rv_b_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rv_a_q <= valid_q[raddr_a];
			rv_b_q <= valid_q[raddr_b];
		end
	end

	assign rdata_a = rv_a_q ? rd_a_q : '0;
	assign rdata_b = rv_b_q ? rd_b_q : '0;

endmodule

/* rtl/ovca_credit_mem.sv */
// Credit count memory: one entry per VC, one read port, one write port.
module ovca_credit_mem #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [AW-1:0] raddr,
	output logic [ovca_pkg::CRED_W-1:0] rdata,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [ovca_pkg::CRED_W-1:0] wdata
);

	import ovca_pkg::*;

	logic [CRED_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [CRED_W-1:0] rd_q;
	logic rv_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// An entry that was never written holds the reset credit count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rv_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rv_q <= valid_q[raddr];
		end
	end

	assign rdata = rv_q ? rd_q : CREDITS_RESET;

endmodule
